>>> hdl/ole_pkg.sv
package ole_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 16;
	localparam int STATUS_W = 3;
	localparam int LENGTH_W = 7;

	// tdata widths padded to whole bytes; tuser is the bare action width
	localparam int IN_TDATA_W  = 48;
	localparam int IN_TUSER_W  = ACTION_W;
	localparam int OUT_TDATA_W = 48;

	localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_DEL_VALUE = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_EXEC
	} state_t;

	// which slot an insert or delete works on
	typedef enum logic [1:0] {
		SEL_FRONT,
		SEL_BACK,
		SEL_POS,
		SEL_MATCH
	} sel_t;

	typedef struct packed {
		logic                load;
		logic                eval;
		logic                fire;
		logic                do_ins;
		logic                do_del;
		sel_t                sel;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                empty;
		logic                full;
		logic                pos_zero;
		logic                pos_one;
		logic                pos_over;
		logic                found;
	} flags_t;

endpackage

>>> hdl/ole_ctrl.sv
module ole_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  ole_pkg::flags_t flags,
	output ole_pkg::cmd_t   cmd
);

	ole_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ole_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ole_pkg::S_IDLE: begin
				if (s_tvalid) state_d = ole_pkg::S_EVAL;
			end
			ole_pkg::S_EVAL: begin
				state_d = ole_pkg::S_EXEC;
			end
			ole_pkg::S_EXEC: begin
				if (slot_free) state_d = ole_pkg::S_IDLE;
			end
			default: state_d = ole_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ole_pkg::S_IDLE);
		cmd        = '0;
		cmd.sel    = ole_pkg::SEL_FRONT;
		cmd.status = ole_pkg::ST_OK;
		cmd.load   = (state_q == ole_pkg::S_IDLE) && s_tvalid;
		cmd.eval   = (state_q == ole_pkg::S_EVAL);
		if (state_q == ole_pkg::S_EXEC && slot_free) begin
			cmd.fire = 1'b1;
			unique case (flags.action)
				ole_pkg::ACT_INS_FRONT, ole_pkg::ACT_INS_BACK: begin
					cmd.sel = (flags.action == ole_pkg::ACT_INS_FRONT) ?
						ole_pkg::SEL_FRONT : ole_pkg::SEL_BACK;
					if (flags.full) cmd.status = ole_pkg::ST_FULL;
					else            cmd.do_ins = 1'b1;
				end
				ole_pkg::ACT_INS_POS: begin
					// position one behaves as insert front, even on an empty list
					priority if (flags.pos_zero) begin
						cmd.status = ole_pkg::ST_BADPOS;
					end else if (flags.pos_one) begin
						cmd.sel = ole_pkg::SEL_FRONT;
						if (flags.full) cmd.status = ole_pkg::ST_FULL;
						else            cmd.do_ins = 1'b1;
					end else if (flags.empty) begin
						cmd.status = ole_pkg::ST_EMPTY;
					end else if (flags.full) begin
						cmd.status = ole_pkg::ST_FULL;
					end else if (flags.pos_over) begin
						cmd.status = ole_pkg::ST_BADPOS;
					end else begin
						cmd.sel    = ole_pkg::SEL_POS;
						cmd.do_ins = 1'b1;
					end
				end
				ole_pkg::ACT_DEL_FRONT, ole_pkg::ACT_DEL_BACK: begin
					cmd.sel = (flags.action == ole_pkg::ACT_DEL_FRONT) ?
						ole_pkg::SEL_FRONT : ole_pkg::SEL_BACK;
					if (flags.empty) cmd.status = ole_pkg::ST_EMPTY;
					else             cmd.do_del = 1'b1;
				end
				ole_pkg::ACT_DEL_VALUE: begin
					cmd.sel = ole_pkg::SEL_MATCH;
					priority if (flags.empty) cmd.status = ole_pkg::ST_EMPTY;
					else if (!flags.found)    cmd.status = ole_pkg::ST_NOTFOUND;
					else                      cmd.do_del = 1'b1;
				end
				default: begin
					// unused action codes: no-op, status ok
				end
			endcase
		end
	end

endmodule

>>> hdl/ole_dpath.sv
module ole_dpath #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic        [ole_pkg::ACTION_W-1:0]  in_action,
	input  logic signed [ole_pkg::VALUE_W-1:0]   in_value,
	input  logic        [ole_pkg::POS_W-1:0]     in_position,
	input  ole_pkg::cmd_t                        cmd,
	output ole_pkg::flags_t                      flags,
	output logic        [ole_pkg::STATUS_W-1:0]  status,
	output logic signed [ole_pkg::VALUE_W-1:0]   removed_value,
	output logic        [ole_pkg::LENGTH_W-1:0]  length
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ole_pkg::POS_W + 1;

	logic        [ole_pkg::ACTION_W-1:0] act_q;
	logic signed [ole_pkg::VALUE_W-1:0]  val_q;
	logic        [ole_pkg::POS_W-1:0]    pos_q;

	logic signed [ole_pkg::VALUE_W-1:0]  cells_q [CAPACITY];
	logic signed [ole_pkg::VALUE_W-1:0]  cells_d [CAPACITY];
	logic signed [ole_pkg::VALUE_W-1:0]  tail_q;
	logic        [CAPACITY-1:0]          match_d, match_q, pre_match;
	logic        [CW-1:0]                count_q, count_d;
	logic        [IW-1:0]                idx;
	logic signed [ole_pkg::VALUE_W-1:0]  rem;

	logic        [ole_pkg::STATUS_W-1:0] status_q;
	logic signed [ole_pkg::VALUE_W-1:0]  removed_q;
	logic        [ole_pkg::LENGTH_W-1:0] length_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			val_q <= in_value;
			pos_q <= in_position;
		end
		if (cmd.eval) begin
			match_q <= match_d;
			tail_q  <= cells_q[IW'(count_q - CW'(1))];
		end
		if (cmd.fire) begin
			status_q  <= cmd.status;
			removed_q <= cmd.do_del ? rem : '0;
			length_q  <= ole_pkg::LENGTH_W'(count_d);
		end
	end

	// parallel compare against every live cell; prefix-OR marks the shift span
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		assign match_d[i]   = (CW'(i) < count_q) && (cells_q[i] == val_q);
		assign pre_match[i] = |match_q[i:0];
	end

	assign flags.action   = act_q;
	assign flags.empty    = (count_q == '0);
	assign flags.full     = (count_q == CW'(CAPACITY));
	assign flags.pos_zero = (pos_q == '0);
	assign flags.pos_one  = (pos_q == ole_pkg::POS_W'(1));
	assign flags.pos_over = ({1'b0, pos_q} > (PW'(count_q) + PW'(1)));
	assign flags.found    = |match_q;

	always_comb begin
		unique case (cmd.sel)
			ole_pkg::SEL_FRONT: idx = '0;
			ole_pkg::SEL_BACK:  idx = cmd.do_ins ? IW'(count_q) : IW'(count_q - CW'(1));
			ole_pkg::SEL_POS:   idx = IW'(pos_q - ole_pkg::POS_W'(1));
			ole_pkg::SEL_MATCH: idx = '0;
			default:            idx = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.sel)
			ole_pkg::SEL_FRONT: rem = cells_q[0];
			ole_pkg::SEL_BACK:  rem = tail_q;
			default:            rem = val_q;
		endcase
	end

	always_comb begin
		int prv;
		int nxt;
		logic del_here;
		for (int i = 0; i < CAPACITY; i++) begin
			prv = (i == 0) ? 0 : i - 1;
			nxt = (i == CAPACITY - 1) ? i : i + 1;
			del_here = (cmd.sel == ole_pkg::SEL_MATCH) ? pre_match[i] : (IW'(i) >= idx);
			cells_d[i] = cells_q[i];
			if (cmd.do_ins) begin
				if (IW'(i) == idx) begin
					cells_d[i] = val_q;
				end else if (IW'(i) > idx) begin
					cells_d[i] = cells_q[prv];
				end
			end else if (cmd.do_del && del_here) begin
				cells_d[i] = cells_q[nxt];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_q[i] <= cells_d[i];
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.do_ins)      count_d = count_q + CW'(1);
		else if (cmd.do_del) count_d = count_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign status        = status_q;
	assign removed_value = removed_q;
	assign length        = length_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_del_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.do_ins && cmd.do_del))
		else $error("insert and delete in one cycle");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire && cmd.do_ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the list");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire && cmd.do_del |=> count_q == $past(count_q) - CW'(1))
		else $error("delete did not shrink the list");

	a_err_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fire && cmd.status != ole_pkg::ST_OK |=> $stable(count_q))
		else $error("failed request changed the list");

endmodule

>>> hdl/ordered_list_engine_top.sv
// channel | dir | tdata (low bit up)                        | tuser
// s_*     | in  | value[31:0], position[47:32]              | action[2:0]
// m_*     | out | status[2:0], removed_value[34:3],          | -
//         |     | length[41:35], zero pad to 48 bits        |
//
// Each request passes through accept, compare and apply. The compare of
// all cells against value is registered before the shift of the cell row.
// A result waiting on m_tready holds the apply step; no new request is
// accepted until that request is applied.
// arst_n clears the list length and control state; cell contents are not reset.
module ordered_list_engine_top #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ole_pkg::IN_TDATA_W-1:0]     s_tdata,  // value, position
	input  logic [ole_pkg::IN_TUSER_W-1:0]     s_tuser,  // action
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ole_pkg::OUT_TDATA_W-1:0]    m_tdata   // status, removed_value, length
);

	ole_pkg::cmd_t   cmd;
	ole_pkg::flags_t flags;

	logic        [ole_pkg::STATUS_W-1:0] status;
	logic signed [ole_pkg::VALUE_W-1:0]  removed_value;
	logic        [ole_pkg::LENGTH_W-1:0] length;

	ole_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.flags    (flags),
		.cmd      (cmd)
	);

	ole_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_action     (s_tuser),
		.in_value      (s_tdata[ole_pkg::VALUE_W-1:0]),
		.in_position   (s_tdata[ole_pkg::VALUE_W +: ole_pkg::POS_W]),
		.cmd           (cmd),
		.flags         (flags),
		.status        (status),
		.removed_value (removed_value),
		.length        (length)
	);

	assign m_tdata = ole_pkg::OUT_TDATA_W'({length, removed_value, status});

endmodule

>>> sim/ole_list_checker.sv
module ole_list_checker #(
	parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [ole_pkg::IN_TUSER_W-1:0]  s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              fail_cnt,
	output int                              pending_cnt,
	output int                              list_len,
	output int                              req_cnt,
	output int                              res_cnt,
	output int                              peak_len,
	output int                              err_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ole_pkg::STATUS_W-1:0] status;
		logic [ole_pkg::VALUE_W-1:0]  removed;
		logic [ole_pkg::LENGTH_W-1:0] length;
	} list_result_t;

	logic [ole_pkg::VALUE_W-1:0] list_cells[$];
	list_result_t                pending_results[$];
	int                          fails;
	int                          requests;
	int                          results;
	int                          peak;
	int                          errors;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fails++;
		$display("[%0t] mismatch on %s: got %0h, expected %0h (result %0d)",
			$time, what, got, want, results);
	endtask

	// mirror of one request against the cell row; failed requests change nothing
	task automatic apply_request(input logic [ole_pkg::ACTION_W-1:0] act,
			input logic [ole_pkg::VALUE_W-1:0] val, input logic [ole_pkg::POS_W-1:0] pos,
			output list_result_t res);
		int                           n;
		int                           hit;
		logic [ole_pkg::STATUS_W-1:0] st;
		logic [ole_pkg::VALUE_W-1:0]  gone;
		n = list_cells.size();
		st = ole_pkg::ST_OK;
		gone = '0;
		hit = -1;
		case (act)
			ole_pkg::ACT_INS_FRONT, ole_pkg::ACT_INS_BACK: begin
				if (n >= CAPACITY)
					st = ole_pkg::ST_FULL;
				else if (act == ole_pkg::ACT_INS_FRONT)
					list_cells.push_front(val);
				else
					list_cells.push_back(val);
			end
			ole_pkg::ACT_INS_POS: begin
				// zero position is rejected first, position one acts as insert front
				if (pos == 0)
					st = ole_pkg::ST_BADPOS;
				else if (pos == 1) begin
					if (n >= CAPACITY)
						st = ole_pkg::ST_FULL;
					else
						list_cells.push_front(val);
				end else if (n == 0)
					st = ole_pkg::ST_EMPTY;
				else if (n >= CAPACITY)
					st = ole_pkg::ST_FULL;
				else if (int'(pos) > n + 1)
					st = ole_pkg::ST_BADPOS;
				else
					list_cells.insert(int'(pos) - 1, val);
			end
			ole_pkg::ACT_DEL_FRONT: begin
				if (n == 0)
					st = ole_pkg::ST_EMPTY;
				else
					gone = list_cells.pop_front();
			end
			ole_pkg::ACT_DEL_BACK: begin
				if (n == 0)
					st = ole_pkg::ST_EMPTY;
				else
					gone = list_cells.pop_back();
			end
			ole_pkg::ACT_DEL_VALUE: begin
				if (n == 0)
					st = ole_pkg::ST_EMPTY;
				else begin
					for (int i = 0; i < n; i++)
						if (hit < 0 && list_cells[i] == val)
							hit = i;
					if (hit < 0)
						st = ole_pkg::ST_NOTFOUND;
					else begin
						gone = list_cells[hit];
						list_cells.delete(hit);
					end
				end
			end
			default: ;
		endcase
		res.status = st;
		res.removed = gone;
		res.length = ole_pkg::LENGTH_W'(list_cells.size());
	endtask

	task automatic check_result(input logic [ole_pkg::OUT_TDATA_W-1:0] data);
		list_result_t got;
		list_result_t want;
		got.status = data[2:0];
		got.removed = data[34:3];
		got.length = data[41:35];
		results++;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected result", data[31:0], 32'h0);
		end else begin
			want = pending_results.pop_front();
			if (got.status != want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.removed != want.removed)
				report_mismatch("removed_value", got.removed, want.removed);
			if (got.length != want.length)
				report_mismatch("length", 32'(got.length), 32'(want.length));
			if (data[ole_pkg::OUT_TDATA_W-1:42] != '0)
				report_mismatch("tdata pad", 32'(data[ole_pkg::OUT_TDATA_W-1:42]), 32'h0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t res;
		if (!arst_n) begin
			list_cells.delete();
			pending_results.delete();
			fails = 0;
			requests = 0;
			results = 0;
			peak = 0;
			errors = 0;
			fail_cnt <= 0;
			pending_cnt <= 0;
			list_len <= 0;
			req_cnt <= 0;
			res_cnt <= 0;
			peak_len <= 0;
			err_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[31:0], s_tdata[47:32], res);
				pending_results.push_back(res);
				requests++;
				if (res.status != ole_pkg::ST_OK)
					errors++;
				if (list_cells.size() > peak)
					peak = list_cells.size();
			end
			// published a step late so the stimulus side reads them race-free
			fail_cnt <= fails;
			pending_cnt <= pending_results.size();
			list_len <= list_cells.size();
			req_cnt <= requests;
			res_cnt <= results;
			peak_len <= peak;
			err_cnt <= errors;
		end
	end

endmodule

>>> sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY  = ole_pkg::CAPACITY_DEF;
	localparam int RAND_REQS = 1200;

	// action codes with no defined operation
	localparam logic [ole_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ole_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

	typedef enum int {
		MODE_GROW,
		MODE_SHRINK,
		MODE_MIXED
	} traffic_mode_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic [ole_pkg::IN_TUSER_W-1:0]  s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata;

	int fail_cnt;
	int pending_cnt;
	int list_len;
	int req_cnt;
	int res_cnt;
	int peak_len;
	int err_cnt;

	bit sender_calm;
	bit receiver_calm;
	int drains;

	ordered_list_engine_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	ole_list_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_cnt(fail_cnt),
		.pending_cnt(pending_cnt),
		.list_len(list_len),
		.req_cnt(req_cnt),
		.res_cnt(res_cnt),
		.peak_len(peak_len),
		.err_cnt(err_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// small pool so deletes by value find their target often
	function automatic logic [ole_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4, 5, 6, 7: return $urandom_range(1, 12);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ole_pkg::POS_W-1:0] pick_pos(input int len);
		case ($urandom_range(0, 19))
			0: return '0;
			1: return 16'd1;
			2: return ole_pkg::POS_W'(len + 1);
			3: return 16'hffff;
			4: return ole_pkg::POS_W'($urandom);
			5: return ole_pkg::POS_W'(len + 2);
			default: return ole_pkg::POS_W'($urandom_range(1, len + 1));
		endcase
	endfunction

	function automatic logic [ole_pkg::ACTION_W-1:0] pick_action(input traffic_mode_t mode);
		int r;
		int ins_pct;
		r = $urandom_range(0, 99);
		if (r < 2)
			return ($urandom_range(0, 1) != 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
		ins_pct = (mode == MODE_GROW) ? 78 : (mode == MODE_SHRINK) ? 25 : 50;
		if ($urandom_range(0, 99) < ins_pct) begin
			case ($urandom_range(0, 2))
				0: return ole_pkg::ACT_INS_FRONT;
				1: return ole_pkg::ACT_INS_BACK;
				default: return ole_pkg::ACT_INS_POS;
			endcase
		end
		case ($urandom_range(0, 2))
			0: return ole_pkg::ACT_DEL_FRONT;
			1: return ole_pkg::ACT_DEL_BACK;
			default: return ole_pkg::ACT_DEL_VALUE;
		endcase
	endfunction

	task automatic send_request(input logic [ole_pkg::ACTION_W-1:0] act,
			input logic [ole_pkg::VALUE_W-1:0] val, input logic [ole_pkg::POS_W-1:0] pos);
		int gap;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pos, val};
		s_tuser <= act;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_cnt != 0);
		drains++;
	endtask

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = pick_gap(receiver_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		traffic_mode_t mode;
		int            sent;
		int            phase_len;
		bit            first_phase;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		drains = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_request(ole_pkg::ACT_DEL_FRONT, 32'h0, 16'h0);
		send_request(ole_pkg::ACT_DEL_BACK, 32'h1, 16'h0);
		send_request(ole_pkg::ACT_DEL_VALUE, 32'h5, 16'h0);
		send_request(ole_pkg::ACT_INS_POS, 32'h9, 16'd2);
		send_request(ole_pkg::ACT_INS_POS, 32'h9, 16'd0);
		send_request(ole_pkg::ACT_INS_POS, 32'hffff_ffff, 16'hffff);
		// build 0x80000000, 7, 0x7fffffff, 7
		send_request(ole_pkg::ACT_INS_POS, 32'h7, 16'd1);
		send_request(ole_pkg::ACT_INS_FRONT, 32'h8000_0000, 16'h0);
		send_request(ole_pkg::ACT_INS_BACK, 32'h7fff_ffff, 16'h0);
		send_request(ole_pkg::ACT_INS_POS, 32'h7, 16'd4);
		send_request(ole_pkg::ACT_INS_POS, 32'h1, 16'd6);
		send_request(ole_pkg::ACT_INS_POS, 32'h1, 16'hffff);
		send_request(ACT_SPARE_LO, 32'hdead_beef, 16'h1234);
		send_request(ACT_SPARE_HI, 32'hffff_ffff, 16'hffff);
		send_request(ole_pkg::ACT_DEL_VALUE, 32'h3, 16'h0);
		// duplicate 7: only the one nearest the front goes
		send_request(ole_pkg::ACT_DEL_VALUE, 32'h7, 16'h0);
		send_request(ole_pkg::ACT_INS_POS, 32'h5555_aaaa, 16'd2);
		send_request(ole_pkg::ACT_DEL_FRONT, 32'h0, 16'h0);
		send_request(ole_pkg::ACT_DEL_BACK, 32'h0, 16'h0);
		send_request(ole_pkg::ACT_DEL_VALUE, 32'h7fff_ffff, 16'h0);
		send_request(ole_pkg::ACT_DEL_BACK, 32'h0, 16'h0);
		send_request(ole_pkg::ACT_DEL_BACK, 32'h0, 16'h0);
		drain_results();

		sent = 0;
		first_phase = 1'b1;
		while (sent < RAND_REQS) begin
			if (first_phase) begin
				mode = MODE_GROW;
				phase_len = 160;
			end else begin
				case ($urandom_range(0, 2))
					0: mode = MODE_GROW;
					1: mode = MODE_SHRINK;
					default: mode = MODE_MIXED;
				endcase
				phase_len = $urandom_range(40, 200);
			end
			first_phase = 1'b0;
			sender_calm = ($urandom_range(0, 4) == 0);
			receiver_calm = ($urandom_range(0, 4) == 0);
			repeat (phase_len) begin
				send_request(pick_action(mode), pick_value(), pick_pos(list_len));
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				drain_results();
		end

		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_cnt != 0);
		repeat (10) @(posedge clk);

		$display("Ran %0d requests, checked %0d results, %0d of them error statuses",
			req_cnt, res_cnt, err_cnt);
		$display("List grew to %0d of %0d entries; sender drained the engine %0d times",
			peak_len, CAPACITY, drains);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
